// ----- sv/nearest_or_oldest_track_update_macros.svh -----
// Assertion macros for the track table update block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef NEAREST_OR_OLDEST_TRACK_UPDATE_MACROS_SVH
`define NEAREST_OR_OLDEST_TRACK_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NOOTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NOOTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/nootu_pkg.sv -----
// Shared types and constants for the track table update block.
// No dependencies; imported by every module of the block.
package nootu_pkg;

    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W = 34;
    localparam logic [15:0] TOL_RESET = 16'd1000;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               flag;
        logic [31:0]        stamp;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        idx_t             idx;
        logic [31:0]      stamp;
        logic [SUM_W-1:0] sum;
    } dist_t;

    function automatic logic [2:0] to_slot3(input idx_t idx);
        logic [IDX_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

// ----- sv/nootu_cell.sv -----
// One slot of the track table, held in a rotating ring of cells.
// Depends on nootu_pkg for entry_t and cell_ctrl_t.
module nootu_cell
    import nootu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     prev_entry,
    input  entry_t     obs_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = obs_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- sv/nootu_dist.sv -----
// Two-stage squared distance unit: per-axis squares, then their sum.
// Depends on nootu_pkg for entry_t and dist_t.
module nootu_dist
    import nootu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid,
    input  logic   last,
    input  idx_t   idx,
    input  entry_t head,
    input  entry_t obs,
    output dist_t  result
);

    logic        a_valid_reg;
    logic        a_last_reg;
    idx_t        a_idx_reg;
    logic [31:0] a_stamp_reg;
    logic [31:0] sq_x_reg;
    logic [31:0] sq_y_reg;
    logic [31:0] sq_z_reg;
    logic        res_valid_reg;
    dist_t       res_reg;
    dist_t       res_next;

    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [15:0] mag_z;

    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [16:0] m;
        d = {a[15], a} - {b[15], b};
        m = d[16] ? -d : d;
        return m[15:0];
    endfunction

    always_comb
    begin
        mag_x = abs_diff(head.x, obs.x);
        mag_y = abs_diff(head.y, obs.y);
        mag_z = abs_diff(head.z, obs.z);
    end

    always_comb
    begin
        res_next.valid = a_valid_reg;
        res_next.last  = a_last_reg;
        res_next.idx   = a_idx_reg;
        res_next.stamp = a_stamp_reg;
        res_next.sum   = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= valid;
            res_valid_reg <= res_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg  <= last;
        a_idx_reg   <= idx;
        a_stamp_reg <= head.stamp;
        sq_x_reg    <= 32'(mag_x) * 32'(mag_x);
        sq_y_reg    <= 32'(mag_y) * 32'(mag_y);
        sq_z_reg    <= 32'(mag_z) * 32'(mag_z);
        res_reg     <= res_next;
    end

    always_comb
    begin
        result       = res_reg;
        result.valid = res_valid_reg;
    end

endmodule

// ----- sv/nearest_or_oldest_track_update.sv -----
// Requests are taken one at a time: in_stall stays high until the chosen cell is written.
// For each request the cell ring rotates one slot per cycle
// past a single two-stage squared distance unit, then the chosen cell is written.
// A finished result waits in the output register while the next request is taken.
// Reset (async, active low) clears every slot to zero and sets the tolerance to 1000.
module nearest_or_oldest_track_update
    import nootu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tolerance_we,
    input  logic [15:0]        tolerance_mm,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] obs_x,
    input  logic signed [15:0] obs_y,
    input  logic signed [15:0] obs_z,
    input  logic               obs_current,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         slot_written,
    output logic               matched
);

`include "nearest_or_oldest_track_update_macros.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             issuing_reg, issuing_next;
    idx_t             iss_cnt_reg, iss_cnt_next;
    logic [15:0]      tol_reg;
    logic [31:0]      tol2_reg;
    entry_t           obs_reg;
    logic             have_near_reg, have_near_next;
    logic [SUM_W-1:0] best_d_reg, best_d_next;
    idx_t             near_idx_reg, near_idx_next;
    logic [31:0]      old_t_reg, old_t_next;
    idx_t             old_idx_reg, old_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       slot_reg;
    logic             matched_reg;

    logic             accept;
    logic             issue;
    logic             issue_last;
    logic             commit;
    logic             near_ok;
    logic             first;
    idx_t             chosen;
    dist_t            dres;
    entry_t           cell_entry [SLOTS];
    logic [SLOTS-1:0] wr_vec;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign issue      = (state_reg == ST_SCAN) && issuing_reg;
    assign issue_last = (iss_cnt_reg == IDX_W'(SLOTS - 1));
    assign commit     = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign chosen     = have_near_reg ? near_idx_reg : old_idx_reg;

    // Cell ring: cell 0 is the head, each cell takes its upper neighbor on shift.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % SLOTS;
        cell_ctrl_t ctrl;

        assign wr_vec[i]  = commit && (chosen == IDX_W'(i));
        assign ctrl.shift = issue;
        assign ctrl.load  = wr_vec[i];

        nootu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (cell_entry[NXT]),
            .obs_entry  (obs_reg),
            .entry      (cell_entry[i])
        );
    end

    nootu_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (issue),
        .last   (issue_last),
        .idx    (iss_cnt_reg),
        .head   (cell_entry[0]),
        .obs    (obs_reg),
        .result (dres)
    );

    // Running nearest and oldest choice over the distance results.
    always_comb
    begin
        near_ok        = (dres.sum < SUM_W'(tol2_reg));
        first          = (dres.idx == '0);
        have_near_next = have_near_reg;
        best_d_next    = best_d_reg;
        near_idx_next  = near_idx_reg;
        old_t_next     = old_t_reg;
        old_idx_next   = old_idx_reg;
        if (dres.valid)
        begin
            if (first)
            begin
                have_near_next = near_ok;
                best_d_next    = dres.sum;
                near_idx_next  = dres.idx;
                old_t_next     = dres.stamp;
                old_idx_next   = dres.idx;
            end
            else
            begin
                if (near_ok && (!have_near_reg || dres.sum < best_d_reg))
                begin
                    have_near_next = 1'b1;
                    best_d_next    = dres.sum;
                    near_idx_next  = dres.idx;
                end
                if (dres.stamp < old_t_reg)
                begin
                    old_t_next   = dres.stamp;
                    old_idx_next = dres.idx;
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        issuing_next = issuing_reg;
        iss_cnt_next = iss_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_SCAN;
                    issuing_next = 1'b1;
                    iss_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    if (issue_last)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        iss_cnt_next = iss_cnt_reg + IDX_W'(1);
                    end
                end
                // advance once the final slot has left the distance unit
                if (dres.valid && dres.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issuing_reg   <= 1'b0;
            iss_cnt_reg   <= '0;
            tol_reg       <= TOL_RESET;
            tol2_reg      <= 32'(TOL_RESET) * 32'(TOL_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issuing_reg   <= issuing_next;
            iss_cnt_reg   <= iss_cnt_next;
            out_valid_reg <= out_valid_next;
            if (tolerance_we)
            begin
                tol_reg <= tolerance_mm;
            end
            tol2_reg <= 32'(tol_reg) * 32'(tol_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            obs_reg.x     <= obs_x;
            obs_reg.y     <= obs_y;
            obs_reg.z     <= obs_z;
            obs_reg.flag  <= obs_current;
            obs_reg.stamp <= now_ms;
        end
        have_near_reg <= have_near_next;
        best_d_reg    <= best_d_next;
        near_idx_reg  <= near_idx_next;
        old_t_reg     <= old_t_next;
        old_idx_reg   <= old_idx_next;
        if (commit)
        begin
            slot_reg    <= to_slot3(chosen);
            matched_reg <= have_near_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_written = slot_reg;
    assign matched      = matched_reg;

    `NOOTU_ASSERT_NEXT(a_accept_starts_scan, accept,
        (state_reg == ST_SCAN) && issuing_reg && (iss_cnt_reg == '0),
        "accepted request did not start a scan at slot zero")
    `NOOTU_ASSERT_NOW(a_single_write, commit, $onehot(wr_vec),
        "table commit must write exactly one cell")
    `NOOTU_ASSERT_NOW(a_no_result_while_scan, dres.valid, state_reg == ST_SCAN,
        "distance result outside of a scan")
    `NOOTU_ASSERT_NOW(a_result_from_finish, $rose(out_valid_reg),
        $past(state_reg == ST_FINISH),
        "result presented without a finished scan")

endmodule
